[rtl/ryuv_pkg.sv]
// Shared types, constants and register indexes for the RGB to YUV 4:2:0 converter.
`timescale 1ns / 1ps
package ryuv_pkg;

  localparam int MAX_WIDTH = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int DIM_W = 13;
  localparam int COUNT_W = $clog2(MAX_WIDTH > MAX_HEIGHT ? MAX_WIDTH : MAX_HEIGHT);
  localparam int ADDR_W = 24;
  localparam int PIX_W = 8;

  localparam logic [DIM_W-1:0] WIDTH_RESET = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);
  localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(2);

  typedef enum logic [1:0] {
    PLANE_Y = 2'd0,
    PLANE_U = 2'd1,
    PLANE_V = 2'd2
  } plane_t;

  typedef enum logic {
    REG_FRAME_WIDTH = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [COUNT_W-1:0] col;
    logic [COUNT_W-1:0] row;
    logic [DIM_W-1:0]   width;
    logic               frame_end;
  } pos_t;

  typedef struct packed {
    logic [PIX_W-1:0]  y;
    logic [PIX_W-1:0]  u;
    logic [PIX_W-1:0]  v;
    logic [ADDR_W-1:0] y_addr;
    logic [ADDR_W-1:0] c_addr;
    logic              has_chroma;
    logic              frame_end;
  } result_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] value,
                                                 input logic [DIM_W-1:0] max_value);
    logic [DIM_W-1:0] res;
    if (value < DIM_MIN) begin
      res = DIM_MIN;
    end else if (value > max_value) begin
      res = max_value;
    end else begin
      res = value;
    end
    return res;
  endfunction

endpackage

[rtl/ryuv_track.sv]
// Geometry registers and the column and row counters of the pixel stream.
`timescale 1ns / 1ps
module ryuv_track
  import ryuv_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [DIM_W-1:0] cfg_data,
  input  logic             advance,
  output pos_t             pos
);

  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;
  logic [COUNT_W-1:0] col;
  logic [COUNT_W-1:0] row;
  logic [COUNT_W-1:0] col_next;
  logic [COUNT_W-1:0] row_next;
  logic [DIM_W-1:0]   eff_width;
  logic [DIM_W-1:0]   eff_height;
  logic               row_end;
  logic               last_row;

  always_comb begin
    eff_width = clamp_dim(frame_width, DIM_W'(MAX_WIDTH));
    eff_height = clamp_dim(frame_height, DIM_W'(MAX_HEIGHT));
    row_end = (DIM_W'(col) + DIM_W'(1)) >= eff_width;
    last_row = (DIM_W'(row) + DIM_W'(1)) >= eff_height;
    if (row_end) begin
      col_next = '0;
      row_next = last_row ? '0 : row + COUNT_W'(1);
    end else begin
      col_next = col + COUNT_W'(1);
      row_next = row;
    end
    pos.col = col;
    pos.row = row;
    pos.width = eff_width;
    pos.frame_end = row_end && last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      col <= '0;
      row <= '0;
    end else begin
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_FRAME_WIDTH: frame_width <= cfg_data;
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: frame_width <= frame_width;
        endcase
      end
      if (advance) begin
        col <= col_next;
        row <= row_next;
      end
    end
  end

endmodule

[rtl/ryuv_csc.sv]
// Color conversion and plane address arithmetic for one registered pixel.
`timescale 1ns / 1ps
module ryuv_csc
  import ryuv_pkg::*;
(
  input  logic [PIX_W-1:0] red,
  input  logic [PIX_W-1:0] green,
  input  logic [PIX_W-1:0] blue,
  input  pos_t             pos,
  output result_t          res
);

  function automatic logic [PIX_W-1:0] scale_clamp(input logic [16:0] pos_sum,
                                                    input logic [16:0] neg_sum,
                                                    input logic bias_on);
    logic [17:0]        t;
    logic [9:0]         q;
    logic signed [11:0] v;
    logic [PIX_W-1:0]   out_val;
    t = {1'b0, pos_sum} + 18'd32768;
    q = 10'((t - {1'b0, neg_sum}) >> 8);
    v = $signed({2'b00, q}) - 12'sd128 + (bias_on ? 12'sd128 : 12'sd0);
    if (t < {1'b0, neg_sum}) begin
      out_val = '0;
    end else if (v < 12'sd0) begin
      out_val = '0;
    end else if (v > 12'sd255) begin
      out_val = 8'd255;
    end else begin
      out_val = v[PIX_W-1:0];
    end
    return out_val;
  endfunction

  logic [16:0] r_ext;
  logic [16:0] g_ext;
  logic [16:0] b_ext;
  logic [16:0] y_pos;
  logic [16:0] u_pos;
  logic [16:0] u_neg;
  logic [16:0] v_pos;
  logic [16:0] v_neg;
  logic [COUNT_W+DIM_W:0] y_full;
  logic [COUNT_W+DIM_W:0] c_full;

  always_comb begin
    r_ext = 17'(red);
    g_ext = 17'(green);
    b_ext = 17'(blue);
    y_pos = 17'd77 * r_ext + 17'd150 * g_ext + 17'd29 * b_ext;
    u_pos = b_ext << 7;
    u_neg = 17'd43 * r_ext + 17'd85 * g_ext;
    v_pos = r_ext << 7;
    v_neg = 17'd107 * g_ext + 17'd21 * b_ext;

    y_full = (COUNT_W+DIM_W+1)'(pos.row) * (COUNT_W+DIM_W+1)'(pos.width)
           + (COUNT_W+DIM_W+1)'(pos.col);
    c_full = (COUNT_W+DIM_W+1)'(pos.row >> 1) * (COUNT_W+DIM_W+1)'(pos.width >> 1)
           + (COUNT_W+DIM_W+1)'(pos.col >> 1);

    res.y = scale_clamp(y_pos, 17'd0, 1'b0);
    res.u = scale_clamp(u_pos, u_neg, 1'b1);
    res.v = scale_clamp(v_pos, v_neg, 1'b1);
    res.y_addr = y_full[ADDR_W-1:0];
    res.c_addr = c_full[ADDR_W-1:0];
    res.has_chroma = !pos.row[0] && !pos.col[0];
    res.frame_end = pos.frame_end;
  end

endmodule

[rtl/ryuv_emit.sv]
// Result register that sends luma, then U and V for a chroma pixel.
`timescale 1ns / 1ps
module ryuv_emit
  import ryuv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  input  result_t           load_res,
  output logic              load_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        plane,
  output logic [ADDR_W-1:0] address,
  output logic [PIX_W-1:0]  sample,
  output logic              last,
  output logic              frame_done
);

  result_t res;
  logic    res_valid;
  plane_t  idx;
  plane_t  idx_next;
  logic    beat;

  always_comb begin
    last = (idx == PLANE_V) || ((idx == PLANE_Y) && !res.has_chroma);
    frame_done = last && res.frame_end;
    out_valid = res_valid;
    plane = idx;
    beat = res_valid && out_ready;
    load_ready = !res_valid || (beat && last);
    case (idx)
      PLANE_Y: begin
        address = res.y_addr;
        sample = res.y;
        idx_next = PLANE_U;
      end
      PLANE_U: begin
        address = res.c_addr;
        sample = res.u;
        idx_next = PLANE_V;
      end
      PLANE_V: begin
        address = res.c_addr;
        sample = res.v;
        idx_next = PLANE_Y;
      end
      default: begin
        address = res.y_addr;
        sample = res.y;
        idx_next = PLANE_Y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx <= PLANE_Y;
    end else if (load_valid && load_ready) begin
      res_valid <= 1'b1;
      idx <= PLANE_Y;
    end else if (beat) begin
      if (last) begin
        res_valid <= 1'b0;
      end
      idx <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      res <= load_res;
    end
  end

endmodule

[rtl/rgb_to_yuv420_planar_converter.sv]
// Top level of the RGB to planar YUV 4:2:0 converter, BT.601 full range.
// The input beat is registered, then converted and loaded into the result register.
// Throughput: one input beat per cycle unless the result register is busy; a pixel on
// an even row and column holds it for three beats (luma, U, V), others for one.
// Reset clears the counters and both valid flags and sets the geometry to 640 by 480.
`timescale 1ns / 1ps
module rgb_to_yuv420_planar_converter
  import ryuv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [DIM_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PIX_W-1:0]  red,
  input  logic [PIX_W-1:0]  green,
  input  logic [PIX_W-1:0]  blue,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        plane,
  output logic [ADDR_W-1:0] address,
  output logic [PIX_W-1:0]  sample,
  output logic              last,
  output logic              frame_done
);

  pos_t             cur_pos;
  pos_t             pix_pos;
  logic             pix_valid;
  logic [PIX_W-1:0] pix_red;
  logic [PIX_W-1:0] pix_green;
  logic [PIX_W-1:0] pix_blue;
  result_t          conv;
  logic             load_ready;
  logic             accept;

  assign in_ready = !pix_valid || load_ready;
  assign accept = in_valid && in_ready;

  ryuv_track u_track (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .pos       (cur_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (accept) begin
      pix_valid <= 1'b1;
    end else if (load_ready) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_red <= red;
      pix_green <= green;
      pix_blue <= blue;
      pix_pos <= cur_pos;
    end
  end

  ryuv_csc u_csc (
    .red   (pix_red),
    .green (pix_green),
    .blue  (pix_blue),
    .pos   (pix_pos),
    .res   (conv)
  );

  ryuv_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load_valid (pix_valid),
    .load_res   (conv),
    .load_ready (load_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .plane      (plane),
    .address    (address),
    .sample     (sample),
    .last       (last),
    .frame_done (frame_done)
  );

endmodule

[bench/tb_rgb_to_yuv420_planar_converter.sv]
// Self-checking testbench for the RGB to planar YUV 4:2:0 converter.
`timescale 1ns / 1ps
module tb_rgb_to_yuv420_planar_converter;
  import ryuv_pkg::*;

  localparam int TOTAL_PIXELS = 470;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } rgb_pixel_t;

  typedef struct {
    plane_t            plane;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  sample;
    logic              last;
    logic              frame_done;
  } yuv_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic              cfg_index = REG_FRAME_WIDTH;
  logic [DIM_W-1:0]  cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PIX_W-1:0]  red = '0;
  logic [PIX_W-1:0]  green = '0;
  logic [PIX_W-1:0]  blue = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        plane;
  logic [ADDR_W-1:0] address;
  logic [PIX_W-1:0]  sample;
  logic              last;
  logic              frame_done;

  rgb_pixel_t pixel_queue[$];
  yuv_beat_t  yuv_expected[$];

  logic [DIM_W-1:0] geo_width = WIDTH_RESET;
  logic [DIM_W-1:0] geo_height = HEIGHT_RESET;
  int pix_col = 0;
  int pix_row = 0;

  int  errors = 0;
  int  pixels_queued = 0;
  int  pixels_sent = 0;
  int  beats_seen = 0;
  int  frames_seen = 0;
  int  geometries = 0;
  int  quiet_cycles = 0;
  int  send_wait = 0;
  int  recv_wait = 0;
  bit  send_idle = 1'b1;
  bit  recv_idle = 1'b1;
  bit  next_valid;
  bit  next_ready;
  rgb_pixel_t px;
  yuv_beat_t  want;

  rgb_to_yuv420_planar_converter u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .plane      (plane),
    .address    (address),
    .sample     (sample),
    .last       (last),
    .frame_done (frame_done)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int eff_dim(input logic [DIM_W-1:0] value, input int max_value);
    if (value < 2) return 2;
    if (value > max_value) return max_value;
    return int'(value);
  endfunction

  function automatic logic [PIX_W-1:0] to_sample(input int pos, input int neg, input int bias);
    int v;
    v = ((pos + 32768 - neg) >>> 8) - 128 + bias;
    if (v < 0) return '0;
    if (v > 255) return 8'd255;
    return v[PIX_W-1:0];
  endfunction

  task automatic predict_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                               input logic [PIX_W-1:0] b);
    int w;
    int h;
    int chroma_addr;
    bit row_end;
    bit frame_end;
    yuv_beat_t beat;
    w = eff_dim(geo_width, MAX_WIDTH);
    h = eff_dim(geo_height, MAX_HEIGHT);
    row_end = (pix_col + 1 >= w);
    frame_end = row_end && (pix_row + 1 >= h);
    beat.plane = PLANE_Y;
    beat.addr = ADDR_W'(pix_row * w + pix_col);
    beat.sample = to_sample(77 * int'(r) + 150 * int'(g) + 29 * int'(b), 0, 0);
    beat.last = 1'b1;
    beat.frame_done = frame_end;
    if (pix_row[0] == 1'b0 && pix_col[0] == 1'b0) begin
      chroma_addr = (pix_row >> 1) * (w >> 1) + (pix_col >> 1);
      beat.last = 1'b0;
      beat.frame_done = 1'b0;
      yuv_expected.push_back(beat);
      beat.plane = PLANE_U;
      beat.addr = ADDR_W'(chroma_addr);
      beat.sample = to_sample(128 * int'(b), 43 * int'(r) + 85 * int'(g), 128);
      yuv_expected.push_back(beat);
      beat.plane = PLANE_V;
      beat.sample = to_sample(128 * int'(r), 107 * int'(g) + 21 * int'(b), 128);
      beat.last = 1'b1;
      beat.frame_done = frame_end;
    end
    yuv_expected.push_back(beat);
    if (row_end) begin
      pix_col = 0;
      pix_row = (pix_row + 1 >= h) ? 0 : pix_row + 1;
    end else begin
      pix_col = pix_col + 1;
    end
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // Pixel driver: one beat per queued pixel, with a random gap after each while send_idle is set.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_wait = 0;
    end else begin
      next_valid = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        predict_pixel(red, green, blue);
        pixels_sent++;
      end
      if (!next_valid) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pixel_queue.size() > 0) begin
          px = pixel_queue.pop_front();
          red <= px.r;
          green <= px.g;
          blue <= px.b;
          next_valid = 1'b1;
          send_wait = send_idle ? $urandom_range(0, 9) : 0;
        end
      end
      in_valid <= next_valid;
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        beats_seen++;
        if (frame_done) frames_seen++;
        if (yuv_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, actual plane %0d address %0d sample %0d",
                   $time, plane, address, sample);
        end else begin
          want = yuv_expected.pop_front();
          check_field("plane", want.plane, plane);
          check_field("address", want.addr, address);
          check_field("sample", want.sample, sample);
          check_field("last", want.last, last);
          check_field("frame_done", want.frame_done, frame_done);
        end
        recv_wait = recv_idle ? $urandom_range(0, 9) : 0;
      end
      next_ready = 1'b1;
      if (recv_wait > 0) begin
        recv_wait--;
        next_ready = 1'b0;
      end
      out_ready <= next_ready;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic add_pixel(input int r, input int g, input int b);
    rgb_pixel_t p;
    p.r = PIX_W'(r);
    p.g = PIX_W'(g);
    p.b = PIX_W'(b);
    pixel_queue.push_back(p);
    pixels_queued++;
  endtask

  function automatic int rand_component();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  task automatic wait_drain();
    while (pixel_queue.size() > 0 || in_valid || yuv_expected.size() > 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input int value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= DIM_W'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_FRAME_WIDTH) begin
      geo_width = DIM_W'(value);
    end else begin
      geo_height = DIM_W'(value);
    end
  endtask

  task automatic set_geometry(input int w, input int h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    geometries++;
    @(negedge clk);
  endtask

  initial begin
    int w_set;
    int h_set;
    int n_items;
    int sel;
    bit hold_mid;
    bit first_random;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Component extremes and primaries at the reset geometry.
    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    add_pixel(0, 255, 255);
    add_pixel(255, 0, 255);
    add_pixel(255, 255, 0);
    wait_drain();

    // Sizes below the minimum; the column left over from the wide row is past the new width.
    set_geometry(0, 1);
    add_pixel(85, 170, 85);
    add_pixel(170, 85, 170);
    add_pixel(1, 254, 128);
    add_pixel(128, 1, 254);
    wait_drain();

    // Sizes above the maximum, with every data bit set.
    set_geometry(8191, 8191);
    add_pixel(255, 0, 0);
    add_pixel(0, 0, 255);
    add_pixel(127, 128, 129);
    wait_drain();

    // Odd width: the chroma stride rounds down.
    set_geometry(5, 3);
    repeat (6) add_pixel(rand_component(), rand_component(), rand_component());
    wait_drain();

    // Smallest frame; the shrink happens with the counters mid-frame.
    set_geometry(2, 2);
    repeat (4) add_pixel(rand_component(), rand_component(), rand_component());
    wait_drain();

    first_random = 1'b1;
    while (pixels_queued < TOTAL_PIXELS) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) w_set = $urandom_range(0, 1);
      else if (sel == 1) w_set = $urandom_range(4096, 8191);
      else if (sel == 2) w_set = $urandom_range(10, 4096);
      else w_set = $urandom_range(2, 9);
      sel = $urandom_range(0, 9);
      if (sel == 0) h_set = $urandom_range(0, 1);
      else if (sel == 1) h_set = $urandom_range(4096, 8191);
      else if (sel == 2) h_set = $urandom_range(7, 4096);
      else h_set = $urandom_range(2, 6);
      set_geometry(w_set, h_set);

      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      n_items = eff_dim(geo_width, MAX_WIDTH) * eff_dim(geo_height, MAX_HEIGHT);
      if (n_items <= 60) begin
        n_items = n_items * $urandom_range(1, 2);
      end else begin
        n_items = $urandom_range(8, 40);
      end
      hold_mid = first_random || ($urandom_range(0, 3) == 0);
      first_random = 1'b0;
      for (int i = 0; i < n_items; i++) begin
        if (hold_mid && i == n_items / 2) wait_drain();
        add_pixel(rand_component(), rand_component(), rand_component());
      end
      wait_drain();
    end

    if (yuv_expected.size() != 0) begin
      errors++;
      $display("%0t: %0d expected beats never arrived", $time, yuv_expected.size());
    end
    $display("Sent %0d pixels under %0d frame geometries; checked %0d result beats.",
             pixels_sent, geometries, beats_seen);
    $display("Frame ends observed: %0d, including minimum, odd and clamped sizes.", frames_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ryuv_pkg.sv
rtl/ryuv_track.sv
rtl/ryuv_csc.sv
rtl/ryuv_emit.sv
rtl/rgb_to_yuv420_planar_converter.sv
bench/tb_rgb_to_yuv420_planar_converter.sv
